FILE: rtl/ift_pkg.sv
// Shared constants and types for the interpolating frequency table.
`default_nettype none
package ift_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 16;
    localparam int ROW_W    = $clog2(MAX_ROWS) + 1;
    localparam int COL_W    = 4;
    localparam int NCOL_W   = 5;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int WGT_W    = 16;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADCOL = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam logic MODE_SET = 1'b0;
    localparam logic MODE_GET = 1'b1;

    localparam logic [2:0] ADDR_NUM_COLS = 3'd0;
    localparam logic [2:0] ADDR_MIN_GAP  = 3'd4;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_INSERT
    } cmd_op_t;

    typedef struct packed {
        logic [KEY_W-1:0]                 key;
        logic [MAX_COLS-1:0][VAL_W-1:0]   vals;
    } row_t;

    // bracket found so far along the chain
    typedef struct packed {
        logic             lo_found;
        logic [KEY_W-1:0] lo_key;
        logic [VAL_W-1:0] lo_val;
        logic             hi_found;
        logic [KEY_W-1:0] hi_key;
        logic [VAL_W-1:0] hi_val;
    } carry_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [KEY_W-1:0] key;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/interpolating_frequency_table.sv
// Interpolating frequency table: top level with control, cell chain and APB registers.
// Usage:
//   s_ channel takes one beat per item: mode (0 set, 1 get), freq key in kHz,
//   col, value and interpolate. m_ channel returns one beat per item with
//   status and result_value. Registers num_cols (0x0) and
//   min_interp_interval (0x4) sit on the APB port; write them only while idle.
// Operation:
//   Each row lives in one cell of a chain of 64; the bracketing rows ripple
//   down the chain one cell a cycle during the scan. A set then commits in
//   the decide state (an insert moves the insertion point and every row past
//   it up at once). A get that falls between two rows adds a bit-serial
//   division, and interpolating adds a multiply and a round-and-saturate state.
//   One item is worked at a time: the next is accepted only once the result
//   of the last has been loaded into the output register.
// Reset clears the row count and min_interp_interval and sets num_cols to 8; row storage is left as it is.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and worked up to its result, which then waits.
`default_nettype none
module interpolating_frequency_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [31:0] s_freq,
    input  wire logic [3:0]  s_col,
    input  wire logic [31:0] s_value,
    input  wire logic        s_interpolate,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_result_value,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ift_pkg::*;

    localparam int SCAN_W = $clog2(MAX_ROWS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DIV,
        S_MUL,
        S_SUM,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [NCOL_W-1:0]   num_cols_reg;
    logic [KEY_W-1:0]    min_gap_reg;
    logic [ROW_W-1:0]    row_count_reg;
    logic [SCAN_W-1:0]   scan_reg;
    logic                mode_reg;
    logic [KEY_W-1:0]    freq_reg;
    logic [COL_W-1:0]    col_reg;
    logic [VAL_W-1:0]    value_reg;
    logic                interp_reg;
    logic [1:0]          res_status_reg;
    logic [VAL_W-1:0]    res_value_reg;
    logic signed [50:0]  prod_reg;
    logic                m_valid_reg;
    logic [1:0]          m_status_reg;
    logic [VAL_W-1:0]    m_value_reg;

    cmd_t                cmd;
    logic [MAX_ROWS-1:0] lt;
    row_t                rows   [MAX_ROWS];
    carry_t              carries[MAX_ROWS];
    carry_t              fin;
    logic                bad_col;
    logic                exact;
    logic [KEY_W-1:0]    gap;
    logic                div_start;
    logic                div_done;
    logic [WGT_W-1:0]    wgt;
    logic signed [32:0]  diff;
    logic signed [34:0]  rnd;
    logic signed [35:0]  sum;
    logic [VAL_W-1:0]    sat;
    logic                apb_wr;

    assign fin     = carries[MAX_ROWS-1];
    assign bad_col = {1'b0, col_reg} >= num_cols_reg;
    assign exact   = fin.hi_found && (fin.hi_key == freq_reg);
    assign gap     = fin.hi_key - fin.lo_key;

    always_comb begin
        cmd.key   = freq_reg;
        cmd.col   = col_reg;
        cmd.value = value_reg;
        cmd.op    = CMD_NONE;
        if (state_reg == S_DECIDE && mode_reg == MODE_SET && !bad_col) begin
            if (exact) begin
                cmd.op = CMD_WRITE;
            end else if (row_count_reg < ROW_W'(MAX_ROWS)) begin
                cmd.op = CMD_INSERT;
            end
        end
    end

    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
        carry_t c_in;
        logic   p_lt;
        logic   n_lt;
        row_t   p_row;
        if (i == 0) begin : g_head
            assign c_in  = '0;
            assign p_lt  = 1'b0;
            assign p_row = rows[0];
        end else begin : g_body
            assign c_in  = carries[i-1];
            assign p_lt  = lt[i-1];
            assign p_row = rows[i-1];
        end
        if (i == MAX_ROWS - 1) begin : g_tail
            assign n_lt = 1'b0;
        end else begin : g_mid
            assign n_lt = lt[i+1];
        end
        ift_cell u_cell (
            .aclk      (aclk),
            .idx       (ROW_W'(i)),
            .row_count (row_count_reg),
            .cmd       (cmd),
            .prev_lt   (p_lt),
            .next_lt   (n_lt),
            .lt        (lt[i]),
            .prev_row  (p_row),
            .row       (rows[i]),
            .carry_in  (c_in),
            .carry_out (carries[i])
        );
    end

    assign div_start = (state_reg == S_DECIDE) && mode_reg == MODE_GET && !bad_col
                       && row_count_reg != '0 && fin.hi_found && fin.lo_found && !exact;

    ift_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (freq_reg - fin.lo_key),
        .den     (gap),
        .done    (div_done),
        .quot    (wgt)
    );

    // floor shift gives the round-half-up result for either sign
    assign diff = $signed({fin.hi_val[VAL_W-1], fin.hi_val})
                - $signed({fin.lo_val[VAL_W-1], fin.lo_val});
    assign rnd  = 35'((prod_reg + 51'sd32768) >>> 16);
    assign sum  = 36'($signed(fin.lo_val)) + 36'(rnd);

    always_comb begin
        if (sum > 36'sd2147483647) begin
            sat = 32'h7FFF_FFFF;
        end else if (sum < -36'sd2147483648) begin
            sat = 32'h8000_0000;
        end else begin
            sat = sum[VAL_W-1:0];
        end
    end

    assign apb_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_result_value = m_value_reg;

    always_comb begin
        unique case (paddr)
            ADDR_NUM_COLS: prdata = {{(32-NCOL_W){1'b0}}, num_cols_reg};
            ADDR_MIN_GAP:  prdata = min_gap_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= NCOL_W'(8);
            min_gap_reg  <= '0;
        end else if (apb_wr) begin
            if (paddr[2]) begin
                min_gap_reg <= pwdata;
            end else begin
                num_cols_reg <= pwdata[NCOL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            row_count_reg <= '0;
            scan_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // the output state loads the next beat itself
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg   <= s_mode;
                        freq_reg   <= s_freq;
                        col_reg    <= s_col;
                        value_reg  <= s_value;
                        interp_reg <= s_interpolate;
                        scan_reg   <= '0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // let the bracket ripple through every cell
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == SCAN_W'(MAX_ROWS)) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    priority if (bad_col) begin
                        res_status_reg <= ST_BADCOL;
                        res_value_reg  <= '0;
                        state_reg      <= S_OUT;
                    end else if (mode_reg == MODE_SET) begin
                        res_value_reg <= '0;
                        state_reg     <= S_OUT;
                        if (!exact && row_count_reg >= ROW_W'(MAX_ROWS)) begin
                            res_status_reg <= ST_FULL;
                        end else begin
                            res_status_reg <= ST_OK;
                            if (!exact) begin
                                row_count_reg <= row_count_reg + 1'b1;
                            end
                        end
                    end else if (row_count_reg == '0) begin
                        res_status_reg <= ST_EMPTY;
                        res_value_reg  <= '0;
                        state_reg      <= S_OUT;
                    end else if (!fin.hi_found) begin
                        res_status_reg <= ST_OK;
                        res_value_reg  <= fin.lo_val;
                        state_reg      <= S_OUT;
                    end else if (!fin.lo_found || exact) begin
                        res_status_reg <= ST_OK;
                        res_value_reg  <= fin.hi_val;
                        state_reg      <= S_OUT;
                    end else begin
                        res_status_reg <= ST_OK;
                        state_reg      <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (!interp_reg || gap <= min_gap_reg) begin
                            res_value_reg <= wgt[WGT_W-1] ? fin.hi_val : fin.lo_val;
                            state_reg     <= S_OUT;
                        end else begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg  <= 51'(diff * $signed({1'b0, wgt}));
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    res_value_reg <= sat;
                    state_reg     <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_value_reg  <= res_value_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_count_reg <= ROW_W'(MAX_ROWS))
        else $error("row count beyond table size");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> row_count_reg >= $past(row_count_reg))
        else $error("row count shrank");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_result_value == '0)
        else $error("empty status with a value");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while busy");

endmodule
`default_nettype wire

FILE: rtl/ift_cell.sv
// One table row: key, column values, and its stage of the bracket chain.
`default_nettype none
module ift_cell (
    input  wire logic                 aclk,
    input  wire logic [ift_pkg::ROW_W-1:0] idx,
    input  wire logic [ift_pkg::ROW_W-1:0] row_count,
    input  wire ift_pkg::cmd_t        cmd,
    input  wire logic                 prev_lt,
    input  wire logic                 next_lt,
    output logic                      lt,
    input  wire ift_pkg::row_t        prev_row,
    output ift_pkg::row_t             row,
    input  wire ift_pkg::carry_t      carry_in,
    output ift_pkg::carry_t           carry_out
);
    import ift_pkg::*;

    row_t   row_reg;
    row_t   row_next;
    carry_t carry_reg;
    carry_t carry_next;
    logic   valid;
    logic   is_first;
    logic   own_lo;
    logic   own_hi;
    logic   shift;

    assign valid    = idx < row_count;
    assign is_first = (idx == '0);
    assign lt       = valid && (row_reg.key < cmd.key);
    assign own_lo   = lt && !next_lt;
    assign own_hi   = valid && !lt && (prev_lt || is_first);
    // insertion point and everything past it move up by one
    assign shift    = !is_first && !prev_lt;
    assign row      = row_reg;
    assign carry_out = carry_reg;

    always_comb begin
        carry_next = carry_in;
        if (own_lo) begin
            carry_next.lo_found = 1'b1;
            carry_next.lo_key   = row_reg.key;
            carry_next.lo_val   = row_reg.vals[cmd.col];
        end
        if (own_hi) begin
            carry_next.hi_found = 1'b1;
            carry_next.hi_key   = row_reg.key;
            carry_next.hi_val   = row_reg.vals[cmd.col];
        end
    end

    always_comb begin
        row_next = row_reg;
        unique case (cmd.op)
            CMD_WRITE: begin
                if (valid && row_reg.key == cmd.key) begin
                    row_next.vals[cmd.col] = cmd.value;
                end
            end
            CMD_INSERT: begin
                if (!lt && (prev_lt || is_first)) begin
                    row_next.key            = cmd.key;
                    row_next.vals           = '0;
                    row_next.vals[cmd.col]  = cmd.value;
                end else if (shift) begin
                    row_next = prev_row;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        row_reg   <= row_next;
        carry_reg <= carry_next;
    end

endmodule
`default_nettype wire

FILE: rtl/ift_div.sv
// Restoring divider for the Q0.16 interpolation weight, one bit a cycle.
`default_nettype none
module ift_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [ift_pkg::KEY_W-1:0] num,
    input  wire logic [ift_pkg::KEY_W-1:0] den,
    output logic                           done,
    output logic [ift_pkg::WGT_W-1:0]      quot
);
    import ift_pkg::*;

    localparam int CNT_W = $clog2(WGT_W + 1);

    logic [KEY_W:0]   rem_reg;
    logic [KEY_W:0]   rem_next;
    logic [WGT_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [KEY_W:0]   shifted;
    logic             take;

    assign shifted  = {rem_reg[KEY_W-1:0], 1'b0};
    assign take     = shifted >= {1'b0, den};
    assign rem_next = take ? shifted - {1'b0, den} : shifted;
    assign done     = !busy_reg && (cnt_reg == CNT_W'(WGT_W));
    assign quot     = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= {1'b0, num};
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[WGT_W-2:0], take};
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WGT_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: dv/ift_checker.sv
// Checker for the interpolating frequency table: predicts every beat and compares results.
module ift_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_freq,
    input  logic [3:0]  s_col,
    input  logic [31:0] s_value,
    input  logic        s_interpolate,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_result_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending
);
    import ift_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } lookup_res_t;

    logic [NCOL_W-1:0] col_count;
    logic [31:0]       min_gap;
    int                row_total;
    logic [31:0]       key_tbl [MAX_ROWS];
    logic [31:0]       val_tbl [MAX_ROWS][MAX_COLS];
    lookup_res_t       lookups_due [$];

    // Advance the table model by one beat and return what the block should answer.
    function automatic lookup_res_t table_step(input logic md, input logic [31:0] f,
                                               input logic [3:0] c, input logic [31:0] v,
                                               input logic ip);
        lookup_res_t res;
        int          pos;
        int          lim;
        longint      lo_k, hi_k, gap, w, lov, hiv, t, r;
        res.status = ST_OK;
        res.value  = '0;
        lim = (col_count > MAX_COLS) ? MAX_COLS : int'(col_count);
        pos = 0;
        while (pos < row_total && key_tbl[pos] < f) pos++;
        if (int'(c) >= lim) begin
            res.status = ST_BADCOL;
        end else if (md == MODE_SET) begin
            if (!(pos < row_total && key_tbl[pos] == f)) begin
                if (row_total >= MAX_ROWS) begin
                    res.status = ST_FULL;
                    return res;
                end
                for (int rr = row_total; rr > pos; rr--) begin
                    key_tbl[rr] = key_tbl[rr-1];
                    for (int cc = 0; cc < MAX_COLS; cc++) val_tbl[rr][cc] = val_tbl[rr-1][cc];
                end
                key_tbl[pos] = f;
                for (int cc = 0; cc < MAX_COLS; cc++) val_tbl[pos][cc] = '0;
                row_total++;
            end
            val_tbl[pos][c] = v;
        end else if (row_total == 0) begin
            res.status = ST_EMPTY;
        end else if (pos >= row_total) begin
            res.value = val_tbl[row_total-1][c];
        end else if (pos == 0 || key_tbl[pos] == f) begin
            res.value = val_tbl[pos][c];
        end else begin
            lo_k = longint'(key_tbl[pos-1]);
            hi_k = longint'(key_tbl[pos]);
            gap  = hi_k - lo_k;
            w    = ((longint'(f) - lo_k) <<< 16) / gap;
            if (!ip || gap <= longint'(min_gap)) begin
                res.value = (w >= 32768) ? val_tbl[pos][c] : val_tbl[pos-1][c];
            end else begin
                lov = longint'(signed'(val_tbl[pos-1][c]));
                hiv = longint'(signed'(val_tbl[pos][c]));
                // round half up: floor of (d*w + half) / 2^16
                t = (hiv - lov) * w + 32768;
                r = lov + (t >>> 16);
                if (r > 64'sd2147483647) r = 64'sd2147483647;
                if (r < -64'sd2147483648) r = -64'sd2147483648;
                res.value = r[31:0];
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        lookup_res_t got, want;
        if (!aresetn) begin
            col_count  = NCOL_W'(8);
            min_gap    = '0;
            row_total  = 0;
            mismatches = 0;
            lookups_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_NUM_COLS) col_count = pwdata[NCOL_W-1:0];
                else if (paddr == ADDR_MIN_GAP) min_gap = pwdata;
            end
            if (s_valid && s_ready)
                lookups_due.push_back(table_step(s_mode, s_freq, s_col, s_value,
                                                 s_interpolate));
            if (m_valid && m_ready) begin
                got.status = m_status;
                got.value  = m_result_value;
                if (lookups_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d value %h",
                                 got.status, got.value);
                end else begin
                    want = lookups_due.pop_front();
                    if (got.status !== want.status || got.value !== want.value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                                     want.status, got.status, want.value, got.value);
                    end
                end
            end
        end
        pending = lookups_due.size();
    end

endmodule

FILE: dv/tb_interpolating_frequency_table.sv
// Testbench top for the interpolating frequency table: stimulus, idling and verdict.
module tb_interpolating_frequency_table;
    import ift_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = MODE_SET;
    logic [31:0] s_freq = '0;
    logic [3:0]  s_col = '0;
    logic [31:0] s_value = '0;
    logic        s_interpolate = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_result_value;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;
    logic [31:0] key_pool [90];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    interpolating_frequency_table i_dut (.*);

    ift_checker i_checker (.*);

    initial begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: random ready bursts, one long hold-off on request.
    initial begin
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (600) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
        end
    end

    task automatic send_beat(input logic md, input logic [31:0] f, input logic [3:0] c,
                             input logic [31:0] v, input logic ip);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_mode = md;
        s_freq = f;
        s_col = c;
        s_value = v;
        s_interpolate = ip;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Drain outstanding lookups, let the block settle, then reprogram both registers.
    task automatic reconfigure(input logic [31:0] ncols, input logic [31:0] gap);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        apb_write(ADDR_NUM_COLS, ncols);
        apb_write(ADDR_MIN_GAP, gap);
    endtask

    function automatic logic [31:0] pick_freq();
        logic [31:0] k;
        k = key_pool[$urandom_range(0, 89)];
        case ($urandom_range(0, 7))
            0, 1:    return k;
            2, 3:    return k + $urandom_range(0, 40) - 20;
            4:       return $urandom();
            5:       return k + $urandom_range(0, 65535);
            6:       return 32'd0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_burst(input int count, input int col_hi);
        for (int n = 0; n < count; n++) begin
            if (n == 200 && col_hi == 8) hold_req = 1'b1;
            if ($urandom_range(0, 9) < 4)
                send_beat(MODE_SET, key_pool[$urandom_range(0, 89)],
                          4'($urandom_range(0, col_hi)), pick_value(),
                          1'($urandom_range(0, 1)));
            else
                send_beat(MODE_GET, pick_freq(), 4'($urandom_range(0, col_hi)),
                          $urandom(), $urandom_range(0, 3) != 0);
        end
    endtask

    initial begin
        for (int i = 0; i < 90; i++) begin
            if (i < 30) key_pool[i] = $urandom();
            else if (i < 60) key_pool[i] = 32'h4000_0000 + i * $urandom_range(1, 3000);
            else key_pool[i] = 32'd100 * i + $urandom_range(0, 50);
        end
        key_pool[0] = 32'd0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: empty table, bad columns, extremes, clamping, exact hit, bracket
        send_beat(MODE_GET, 32'd100, 4'd0, 32'd0, 1'b1);
        send_beat(MODE_SET, 32'd100, 4'd8, 32'd7, 1'b0);
        send_beat(MODE_GET, 32'd100, 4'd15, 32'd0, 1'b0);
        send_beat(MODE_SET, 32'd1000, 4'd0, 32'h7FFF_FFFF, 1'b0);
        send_beat(MODE_SET, 32'd3000, 4'd0, 32'h8000_0000, 1'b0);
        send_beat(MODE_SET, 32'd1000, 4'd7, 32'hFFFF_FFFF, 1'b0);
        send_beat(MODE_GET, 32'd0, 4'd0, 32'd0, 1'b1);
        send_beat(MODE_GET, 32'hFFFF_FFFF, 4'd0, 32'd0, 1'b1);
        send_beat(MODE_GET, 32'd1000, 4'd7, 32'd0, 1'b1);
        send_beat(MODE_GET, 32'd2000, 4'd0, 32'd0, 1'b1);
        send_beat(MODE_GET, 32'd2000, 4'd0, 32'd0, 1'b0);
        send_beat(MODE_GET, 32'd1999, 4'd0, 32'd0, 1'b0);
        send_beat(MODE_GET, 32'd1500, 4'd3, 32'd0, 1'b1);
        send_beat(MODE_SET, 32'd0, 4'd0, 32'd5, 1'b0);
        send_beat(MODE_SET, 32'hFFFF_FFFF, 4'd7, 32'h0001_2345, 1'b1);
        send_beat(MODE_GET, 32'd500, 4'd0, 32'd0, 1'b1);
        send_beat(MODE_GET, 32'hFFFF_FFF0, 4'd7, 32'd0, 1'b1);
        send_beat(MODE_SET, 32'd2000, 4'd0, 32'h0000_0001, 1'b0);
        send_beat(MODE_GET, 32'd2001, 4'd0, 32'd0, 1'b1);

        random_burst(400, 8);
        reconfigure(32'd0, 32'd0);
        send_beat(MODE_SET, 32'd1000, 4'd0, 32'd1, 1'b0);
        send_beat(MODE_GET, 32'd1000, 4'd0, 32'd0, 1'b1);
        reconfigure(32'd16, 32'd1000);
        random_burst(450, 15);
        reconfigure(32'd1, 32'hFFFF_FFFF);
        random_burst(250, 15);
        reconfigure(32'd31, 32'd0);
        random_burst(400, 15);
        reconfigure($urandom_range(2, 15), $urandom_range(0, 100_000));
        random_burst(250, 15);
        calm = 1'b1;
        random_burst(180, 15);

        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
